// File: rtl/core/bprf_pkg.sv
// Shared types, constants and frame-decode function for the bi-phase frame decoder.
// No dependencies.
package bprf_pkg;

  localparam int DUR_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAME_W     = 96;
  localparam int PREAMBLE_W  = 6;
  localparam int GROUPS      = 18;
  localparam int GROUP_LEN   = 5;
  localparam int DATA_PER_GRP = 4;
  localparam int DEC_BYTES   = 9;
  localparam int DEC_BITS    = DEC_BYTES * 8;

  localparam logic [PREAMBLE_W-1:0] PREAMBLE     = 6'b111110;
  localparam logic [5:0]            WANTED_LEN   = 6'd26;

  localparam logic [DUR_W-1:0] SHORT_NOM_RST = 16'd256;
  localparam logic [DUR_W-1:0] LONG_NOM_RST  = 16'd512;
  localparam logic [DUR_W-1:0] JITTER_RST    = 16'd120;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_NOM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_NOM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER    = 2'd2;

  typedef struct packed {
    logic [DUR_W-1:0] short_nominal;
    logic [DUR_W-1:0] long_nominal;
    logic [DUR_W-1:0] jitter_allowance;
  } cfg_t;

  // Status of the bit-decode stage toward the top level
  typedef struct packed {
    logic valid;
    logic pushed;
  } stage_t;

  typedef struct packed {
    logic        frame_found;
    logic [7:0]  xor_key;
    logic [5:0]  card_length;
    logic [1:0]  crc_bits;
    logic [15:0] profile_code;
    logic [7:0]  facility_number;
    logic [15:0] card_number;
  } result_t;

  typedef logic [DEC_BYTES-1:0][7:0] dec_bytes_t;

  // Drop parity bits and bit-reverse each byte. Frame bit p (MSB first)
  // lives at vector index FRAME_W-1-p.
  function automatic dec_bytes_t decode_bytes(input logic [FRAME_W-1:0] frame);
    dec_bytes_t dec;
    int         src;
    dec = '0;
    for (int k = 0; k < DEC_BITS; k++) begin
      src = PREAMBLE_W + (k / DATA_PER_GRP) * GROUP_LEN + (k % DATA_PER_GRP);
      dec[k / 8][k % 8] = frame[FRAME_W - 1 - src];
    end
    return dec;
  endfunction

endpackage

// File: rtl/core/bprf_pulse_if.sv
// Input channel: one pulse duration per transfer.
// Depends on bprf_pkg.
interface bprf_pulse_if;
  import bprf_pkg::*;

  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] pulse_duration;

  modport source (output valid, output pulse_duration, input ready);
  modport sink   (input valid, input pulse_duration, output ready);
endinterface

// File: rtl/core/bprf_result_if.sv
// Output channel: one decode result per transfer.
// Depends on bprf_pkg.
interface bprf_result_if;
  import bprf_pkg::*;

  logic        valid;
  logic        ready;
  logic        frame_found;
  logic [7:0]  xor_key;
  logic [5:0]  card_length;
  logic [1:0]  crc_bits;
  logic [15:0] profile_code;
  logic [7:0]  facility_number;
  logic [15:0] card_number;

  modport source (output valid, output frame_found, output xor_key, output card_length,
                  output crc_bits, output profile_code, output facility_number,
                  output card_number, input ready);
  modport sink   (input valid, input frame_found, input xor_key, input card_length,
                  input crc_bits, input profile_code, input facility_number,
                  input card_number, output ready);
endinterface

// File: rtl/core/bprf_cfg_regs.sv
// Timing window configuration registers.
// Depends on bprf_pkg.
module bprf_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bprf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bprf_pkg::DUR_W-1:0] cfg_data,
  output bprf_pkg::cfg_t             cfg
);
  import bprf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_nominal    <= SHORT_NOM_RST;
      cfg.long_nominal     <= LONG_NOM_RST;
      cfg.jitter_allowance <= JITTER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_NOM: cfg.short_nominal    <= cfg_data;
        REG_LONG_NOM:  cfg.long_nominal     <= cfg_data;
        REG_JITTER:    cfg.jitter_allowance <= cfg_data;
        default: ;     // unknown index ignored
      endcase
    end
  end

endmodule

// File: rtl/core/bprf_bit_decoder.sv
// Pulse classification, pending-short flag and 96-bit frame shift register.
// Depends on bprf_pkg.
module bprf_bit_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  bprf_pkg::cfg_t             cfg,
  input  logic                       load,
  input  logic [bprf_pkg::DUR_W-1:0] dur,
  input  logic                       take,
  output logic [bprf_pkg::FRAME_W-1:0] frame,
  output bprf_pkg::stage_t           status
);
  import bprf_pkg::*;

  logic             pending_short;
  logic             pending_short_next;
  logic             push;
  logic             push_val;
  logic [DUR_W-1:0] short_lo;
  logic [DUR_W-1:0] long_lo;
  logic [DUR_W:0]   short_hi;
  logic [DUR_W:0]   long_hi;
  logic             is_short;
  logic             is_long;

  // Window limits: low saturates at zero, high is one bit wider
  always_comb begin
    short_lo = (cfg.short_nominal >= cfg.jitter_allowance) ?
               cfg.short_nominal - cfg.jitter_allowance : '0;
    long_lo  = (cfg.long_nominal >= cfg.jitter_allowance) ?
               cfg.long_nominal - cfg.jitter_allowance : '0;
    short_hi = {1'b0, cfg.short_nominal} + {1'b0, cfg.jitter_allowance};
    long_hi  = {1'b0, cfg.long_nominal} + {1'b0, cfg.jitter_allowance};
    is_short = (dur >= short_lo) && ({1'b0, dur} <= short_hi);
    is_long  = (dur >= long_lo) && ({1'b0, dur} <= long_hi);
  end

  // Short wins where windows overlap
  always_comb begin
    push               = 1'b0;
    push_val           = 1'b0;
    pending_short_next = 1'b0;
    if (is_short) begin
      push               = pending_short;
      push_val           = 1'b1;
      pending_short_next = !pending_short;
    end else if (is_long) begin
      push = !pending_short;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_short <= 1'b0;
      frame         <= '0;
      status        <= '0;
    end else begin
      if (load) begin
        pending_short <= pending_short_next;
        status.pushed <= push;
        if (push) begin
          frame <= {frame[FRAME_W-2:0], push_val};
        end
      end
      if (load) begin
        status.valid <= 1'b1;
      end else if (take) begin
        status.valid <= 1'b0;
      end
    end
  end

  a_push_clears_pending: assert property (@(posedge clk) disable iff (rst)
    load && push |=> !pending_short)
    else $error("pending short flag left set after a push");

  a_push_shifts: assert property (@(posedge clk) disable iff (rst)
    load && push |=> frame[FRAME_W-1:1] == $past(frame[FRAME_W-2:0]))
    else $error("frame register did not shift on push");

endmodule

// File: rtl/core/bprf_frame_check.sv
// Frame validity check and field extraction on the 96-bit frame register.
// Depends on bprf_pkg.
module bprf_frame_check (
  input  logic [bprf_pkg::FRAME_W-1:0] frame,
  output logic                         valid_frame,
  output bprf_pkg::result_t            fields
);
  import bprf_pkg::*;

  dec_bytes_t raw;
  dec_bytes_t dec;
  logic       preamble_ok;
  logic       parity_ok;

  always_comb begin
    preamble_ok = frame[FRAME_W-1 -: PREAMBLE_W] == PREAMBLE;
    parity_ok   = 1'b1;
    // fifth bit of every group must be zero
    for (int g = 0; g < GROUPS; g++) begin
      if (frame[FRAME_W - 1 - (PREAMBLE_W + g * GROUP_LEN + DATA_PER_GRP)]) begin
        parity_ok = 1'b0;
      end
    end
    raw    = decode_bytes(frame);
    dec[0] = raw[0];
    for (int b = 1; b < DEC_BYTES; b++) begin
      dec[b] = raw[b] ^ raw[0];
    end
    valid_frame = preamble_ok && parity_ok && (dec[1][7:2] == WANTED_LEN);

    fields.frame_found     = valid_frame;
    fields.xor_key         = dec[0];
    fields.card_length     = dec[1][7:2];
    fields.crc_bits        = dec[1][1:0];
    fields.profile_code    = {dec[2], dec[3]};
    fields.facility_number = {dec[4][6:0], dec[5][7]};
    fields.card_number     = {dec[5][6:0], dec[6], dec[7][7]};
  end

endmodule

// File: rtl/core/biphase_rfid_frame_decoder.sv
// Bi-phase card frame decoder, top level. Depends on bprf_pkg, bprf_pulse_if,
// bprf_result_if, bprf_cfg_regs, bprf_bit_decoder and bprf_frame_check.
// Pipeline: an item passes the input reg, the decode/frame reg and the result
//   reg, in that order; a stalled output side holds it back.
// Throughput: one item per cycle; the three-register elastic pipeline keeps
//   accepting while a finished result waits, until all three stages are full.
// Reset (rst, synchronous): clears the frame, the pending-short flag and all
//   valid flags, and loads the window registers with 256 / 512 / 120.
module biphase_rfid_frame_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bprf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bprf_pkg::DUR_W-1:0]     cfg_data,
  bprf_pulse_if.sink                     pulse_in,
  bprf_result_if.source                  result_out
);
  import bprf_pkg::*;

  cfg_t             cfg;
  stage_t           dec_status;
  logic [FRAME_W-1:0] frame;
  logic             frame_ok;
  result_t          check_fields;

  // Stage 0: input register
  logic             in_valid;
  logic [DUR_W-1:0] in_dur;
  // Stage 2: result register
  logic             res_valid;
  result_t          res;

  logic res_rdy;
  logic dec_rdy;
  logic in_rdy;
  logic dec_load;
  logic res_load;

  // Ready chain: a stage takes a new item when empty or when it is moving on
  assign res_rdy  = !res_valid || result_out.ready;
  assign dec_rdy  = !dec_status.valid || res_rdy;
  assign in_rdy   = !in_valid || dec_rdy;
  assign dec_load = in_valid && dec_rdy;
  assign res_load = dec_status.valid && res_rdy;

  assign pulse_in.ready = in_rdy;

  bprf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register; payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_rdy) begin
      in_valid <= pulse_in.valid;
    end
    if (in_rdy && pulse_in.valid) begin
      in_dur <= pulse_in.pulse_duration;
    end
  end

  // Classification updates the frame register as the item moves into stage 1
  bprf_bit_decoder u_dec (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .load   (dec_load),
    .dur    (in_dur),
    .take   (res_load),
    .frame  (frame),
    .status (dec_status)
  );

  // Check runs on the frame as left by the item now in stage 1
  bprf_frame_check u_chk (
    .frame       (frame),
    .valid_frame (frame_ok),
    .fields      (check_fields)
  );

  // Result register: all fields zero unless this item pushed a bit into a valid frame
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_rdy) begin
      res_valid <= dec_status.valid;
    end
    if (res_load) begin
      res <= (dec_status.pushed && frame_ok) ? check_fields : '0;
    end
  end

  assign result_out.valid           = res_valid;
  assign result_out.frame_found     = res.frame_found;
  assign result_out.xor_key         = res.xor_key;
  assign result_out.card_length     = res.card_length;
  assign result_out.crc_bits        = res.crc_bits;
  assign result_out.profile_code    = res.profile_code;
  assign result_out.facility_number = res.facility_number;
  assign result_out.card_number     = res.card_number;

  a_found_length: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_found |-> res.card_length == WANTED_LEN)
    else $error("frame reported with wrong length field");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.frame_found |-> res == '0)
    else $error("fields not cleared on a result without frame");

  a_found_needs_push: assert property (@(posedge clk) disable iff (rst)
    res_load && !dec_status.pushed |=> !res.frame_found)
    else $error("frame reported for an item that pushed no bit");

endmodule

// File: sim/biphase_rfid_frame_decoder_tb.sv
// Self-checking testbench for the bi-phase card frame decoder.
// Depends on bprf_pkg, bprf_pulse_if, bprf_result_if and biphase_rfid_frame_decoder.
`timescale 1ns / 1ps

module biphase_rfid_frame_decoder_tb;
  import bprf_pkg::*;

  // Index 3 is not a register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 3000; // cycles with no transfer on either side
  localparam int PIPE_SETTLE    = 4;    // pipeline depth plus a margin
  localparam int HOLD_CYCLES    = 64;   // long receiver hold-off
  localparam int PHASE_ITEMS    = 80;   // random pulses per window setting

  typedef enum {FRAME_CLEAN, FRAME_FLIP, FRAME_BAD_LEN, FRAME_GLITCH} frame_kind_e;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0] cfg_data;

  bprf_pulse_if  pulse_ch();
  bprf_result_if result_ch();

  biphase_rfid_frame_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pulse_in   (pulse_ch),
    .result_out (result_ch)
  );

  // Shadow of the decoder: window settings, pending-short flag, 96-bit frame.
  // Frame bit p (MSB first on the air) sits at index FRAME_W-1-p.
  cfg_t             model_cfg;
  logic             model_pend;
  logic [FRAME_W-1:0] model_frame;

  result_t expected_results[$];
  result_t next_decode;

  int  pulses_sent;
  int  mismatches = 0;
  int  idle_cycles;
  bit  gaps_on;
  int  hold_req;    // bumped once per requested long hold

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic reset_model();
    model_cfg.short_nominal    = SHORT_NOM_RST;
    model_cfg.long_nominal     = LONG_NOM_RST;
    model_cfg.jitter_allowance = JITTER_RST;
    model_pend  = 1'b0;
    model_frame = '0;
  endtask

  // Inclusive window; low end clamps at 0, high end is kept at 17 bits.
  function automatic bit in_window(input logic [DUR_W-1:0] d, input logic [DUR_W-1:0] nom);
    logic [DUR_W:0] lo;
    logic [DUR_W:0] hi;
    lo = (nom >= model_cfg.jitter_allowance) ?
         {1'b0, nom - model_cfg.jitter_allowance} : '0;
    hi = {1'b0, nom} + {1'b0, model_cfg.jitter_allowance};
    return ({1'b0, d} >= lo) && ({1'b0, d} <= hi);
  endfunction

  // Preamble, zero parity in each group, then de-parity, per-byte bit reversal,
  // unscramble against byte 0 and the length test.
  function automatic result_t check_frame(input logic [FRAME_W-1:0] f);
    result_t    r;
    logic [7:0] dec [DEC_BYTES];
    int         src;
    r = '0;
    if (f[FRAME_W-1 -: PREAMBLE_W] != PREAMBLE)
      return r;
    for (int g = 0; g < GROUPS; g++)
      if (f[FRAME_W-1-(PREAMBLE_W + g*GROUP_LEN + DATA_PER_GRP)] != 1'b0)
        return r;
    for (int b = 0; b < DEC_BYTES; b++)
      dec[b] = '0;
    for (int k = 0; k < DEC_BITS; k++) begin
      src = PREAMBLE_W + (k / DATA_PER_GRP) * GROUP_LEN + (k % DATA_PER_GRP);
      dec[k/8][k%8] = f[FRAME_W-1-src];
    end
    for (int b = 1; b < DEC_BYTES; b++)
      dec[b] = dec[b] ^ dec[0];
    if (dec[1][7:2] != WANTED_LEN)
      return r;
    r.frame_found     = 1'b1;
    r.xor_key         = dec[0];
    r.card_length     = dec[1][7:2];
    r.crc_bits        = dec[1][1:0];
    r.profile_code    = {dec[2], dec[3]};
    r.facility_number = {dec[4][6:0], dec[5][7]};
    r.card_number     = {dec[5][6:0], dec[6], dec[7][7]};
    return r;
  endfunction

  // Advances the shadow state by one pulse and returns the expected result.
  function automatic result_t decode_pulse(input logic [DUR_W-1:0] d);
    logic pushed;
    pushed = 1'b0;
    if (in_window(d, model_cfg.short_nominal)) begin
      // short wins when both windows hold the duration
      if (!model_pend) begin
        model_pend = 1'b1;
      end else begin
        model_frame = {model_frame[FRAME_W-2:0], 1'b1};
        model_pend  = 1'b0;
        pushed      = 1'b1;
      end
    end else if (in_window(d, model_cfg.long_nominal)) begin
      if (!model_pend) begin
        model_frame = {model_frame[FRAME_W-2:0], 1'b0};
        pushed      = 1'b1;
      end else begin
        model_pend = 1'b0; // long after short: drop the half bit
      end
    end else begin
      model_pend = 1'b0;   // out of both windows
    end
    if (pushed)
      return check_frame(model_frame);
    return '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Random duration inside a window, edges picked now and then.
  function automatic logic [DUR_W-1:0] pick_in_window(input logic [DUR_W-1:0] nom);
    int lo;
    int hi;
    logic [DUR_W-1:0] v;
    lo = int'(nom);
    hi = int'(nom) + int'(model_cfg.jitter_allowance);
    lo = (nom >= model_cfg.jitter_allowance) ? lo - int'(model_cfg.jitter_allowance) : 0;
    if (hi > 65535)
      hi = 65535;
    case ($urandom_range(0, 7))
      0:       v = DUR_W'(lo);
      1:       v = DUR_W'(hi);
      default: v = DUR_W'($urandom_range(hi, lo));
    endcase
    return v;
  endfunction

  // Long pulse that tries to avoid the short window when the windows overlap.
  function automatic logic [DUR_W-1:0] pick_long();
    logic [DUR_W-1:0] d;
    d = pick_in_window(model_cfg.long_nominal);
    for (int t = 0; t < 8 && in_window(d, model_cfg.short_nominal); t++)
      d = pick_in_window(model_cfg.long_nominal);
    return d;
  endfunction

  // Valid on-air frame from a key, a CRC field and a length field.
  function automatic logic [FRAME_W-1:0] make_frame(input logic [7:0] key,
                                                     input logic [1:0] crc,
                                                     input logic [5:0] len);
    logic [7:0]       plain [DEC_BYTES];
    logic [7:0]       scr;
    logic [FRAME_W-1:0] f;
    int               src;
    plain[0] = key;
    plain[1] = {len, crc};
    for (int b = 2; b < DEC_BYTES; b++)
      plain[b] = 8'($urandom);
    f = '0;
    f[FRAME_W-1 -: PREAMBLE_W] = PREAMBLE;
    for (int k = 0; k < DEC_BITS; k++) begin
      scr = (k < 8) ? plain[0] : plain[k/8] ^ key;
      src = PREAMBLE_W + (k / DATA_PER_GRP) * GROUP_LEN + (k % DATA_PER_GRP);
      f[FRAME_W-1-src] = scr[k%8];
    end
    return f;
  endfunction

  // One transfer on the pulse channel. Called and returns at a falling edge;
  // valid stays high on return so back-to-back pulses need no toggle.
  task automatic send_pulse(input logic [DUR_W-1:0] d);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      pulse_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    pulse_ch.valid          = 1'b1;
    pulse_ch.pulse_duration = d;
    @(posedge clk);
    while (!pulse_ch.ready)
      @(posedge clk);
    expected_results.push_back(decode_pulse(d));
    pulses_sent++;
    @(negedge clk);
  endtask

  task automatic wait_all_decoded();
    pulse_ch.valid = 1'b0;
    while (expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_SHORT_NOM: model_cfg.short_nominal    = val;
      REG_LONG_NOM:  model_cfg.long_nominal     = val;
      REG_JITTER:    model_cfg.jitter_allowance = val;
      default:       ; // ignored by the block
    endcase
  endtask

  // Windows only change with the pipeline empty.
  task automatic set_windows(input logic [DUR_W-1:0] s, input logic [DUR_W-1:0] l,
                             input logic [DUR_W-1:0] j);
    wait_all_decoded();
    repeat (PIPE_SETTLE) @(negedge clk);
    write_reg(REG_SHORT_NOM, s);
    write_reg(REG_LONG_NOM, l);
    write_reg(REG_JITTER, j);
  endtask

  // Bits go out oldest first: 1 as two shorts, 0 as one long. A leftover
  // half bit is cleared first with a long. Optional noise pulse mid-frame.
  task automatic send_frame(input logic [FRAME_W-1:0] f, input int glitch_at);
    if (model_pend)
      send_pulse(pick_long());
    for (int p = 0; p < FRAME_W; p++) begin
      if (p == glitch_at)
        send_pulse(DUR_W'($urandom_range(0, 65535)));
      if (f[FRAME_W-1-p]) begin
        send_pulse(pick_in_window(model_cfg.short_nominal));
        send_pulse(pick_in_window(model_cfg.short_nominal));
      end else begin
        send_pulse(pick_long());
      end
    end
  endtask

  task automatic send_random_frame(input frame_kind_e kind);
    logic [FRAME_W-1:0] f;
    logic [5:0]         len;
    int                 glitch;
    int                 pos;
    len    = WANTED_LEN;
    glitch = -1;
    if (kind == FRAME_BAD_LEN) begin
      len = 6'($urandom);
      if (len == WANTED_LEN)
        len = ~len;
    end
    f = make_frame(8'($urandom), 2'($urandom), len);
    if (kind == FRAME_FLIP) begin
      pos    = $urandom_range(0, FRAME_W-1);
      f[pos] = ~f[pos];
    end
    if (kind == FRAME_GLITCH)
      glitch = $urandom_range(0, FRAME_W-1);
    send_frame(f, glitch);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0:       send_pulse(pick_in_window(model_cfg.short_nominal));
        1:       send_pulse(pick_long());
        default: send_pulse(DUR_W'($urandom_range(0, 65535)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset windows: short 136..376, long 392..632.
  task automatic test_window_edges();
    send_pulse(16'd0);      // below everything
    send_pulse(16'hFFFF);   // saturated maximum
    send_pulse(16'd136);    // short, low edge
    send_pulse(16'd376);    // short, high edge -> bit 1
    send_pulse(16'd135);
    send_pulse(16'd377);    // gap between windows
    send_pulse(16'd392);    // long, low edge -> bit 0
    send_pulse(16'd632);    // long, high edge -> bit 0
    send_pulse(16'd633);
    send_pulse(16'd256);
    send_pulse(16'd512);    // long after short, nothing pushed
    send_pulse(16'd256);
    send_pulse(16'd0);      // out of window clears the half bit
    send_pulse(16'd256);
    send_pulse(16'd256);
  endtask

  // Overlapping windows: 200..400 short, 250..450 long.
  task automatic test_overlap_priority();
    set_windows(16'd300, 16'd350, 16'd100);
    send_pulse(16'd320);
    send_pulse(16'd320);    // in both -> short pair -> bit 1
    send_pulse(16'd420);    // long only -> bit 0
  endtask

  task automatic test_config_extremes();
    // zero jitter, nominals at both ends of the range
    set_windows(16'd0, 16'hFFFF, 16'd0);
    send_pulse(16'd0);
    send_pulse(16'hFFFF);
    send_pulse(16'd1);
    // full jitter: short window spans past 16 bits and takes everything
    set_windows(16'hFFFF, 16'd0, 16'hFFFF);
    send_pulse(16'd0);
    send_pulse(16'hFFFF);
    send_pulse(DUR_W'($urandom_range(0, 65535)));
    // identical windows
    set_windows(16'hFFFF, 16'hFFFF, 16'd0);
    send_pulse(16'hFFFF);
    send_pulse(16'hFFFE);
    // write to the unused index must not disturb the windows
    wait_all_decoded();
    write_reg(REG_UNUSED, DUR_W'($urandom_range(0, 65535)));
    send_pulse(16'hFFFF);
    send_pulse(16'hFFFF);
  endtask

  // Mostly well-formed frames, some broken ones and some noise, over
  // several window settings.
  task automatic test_random_traffic();
    int phase_end;
    int pick;
    int s;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_windows(SHORT_NOM_RST, LONG_NOM_RST, JITTER_RST);
        1: set_windows(16'd100, 16'd200, 16'd0);
        2: begin
          s = $urandom_range(30, 4000);
          set_windows(DUR_W'(s), DUR_W'(2*s + $urandom_range(0, s/4)),
                      DUR_W'($urandom_range(0, s/3)));
        end
        default: set_windows(16'd32000, 16'hFFFF, 16'd5000);
      endcase
      phase_end = pulses_sent + PHASE_ITEMS;
      while (pulses_sent < phase_end) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 60)
          send_random_frame(FRAME_CLEAN);
        else if (pick < 72)
          send_random_frame(FRAME_FLIP);
        else if (pick < 80)
          send_random_frame(FRAME_BAD_LEN);
        else if (pick < 88)
          send_random_frame(FRAME_GLITCH);
        else
          send_noise($urandom_range(1, 12));
      end
    end
    gaps_on = 1'b1;
  endtask

  // Receiver holds off while pulses keep coming; the pipe fills and stalls.
  task automatic test_backpressure();
    set_windows(SHORT_NOM_RST, LONG_NOM_RST, JITTER_RST);
    gaps_on = 1'b0;
    hold_req++;
    send_noise(40);
    gaps_on = 1'b1;
  endtask

  // Sender stops until every result is back, then resumes mid-frame.
  task automatic test_drain_pause();
    logic [FRAME_W-1:0] f;
    f = make_frame(8'($urandom), 2'($urandom), WANTED_LEN);
    if (model_pend)
      send_pulse(pick_long());
    for (int p = 0; p < FRAME_W; p++) begin
      if (p == FRAME_W/2)
        wait_all_decoded();
      if (f[FRAME_W-1-p]) begin
        send_pulse(pick_in_window(model_cfg.short_nominal));
        send_pulse(pick_in_window(model_cfg.short_nominal));
      end else begin
        send_pulse(pick_long());
      end
    end
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_final_frame();
    gaps_on = 1'b0;
    send_random_frame(FRAME_CLEAN);
    send_noise(8);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: random stall bursts, plus one long hold when requested.
  initial begin : receiver
    int hold_cnt;
    int stall_cnt;
    int hold_seen;
    hold_cnt = 0;
    stall_cnt = 0;
    hold_seen = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_cnt  = HOLD_CYCLES;
        hold_seen = hold_req;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result_ch.ready = 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        result_ch.ready = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(1, 7) - 1;
        result_ch.ready = 1'b0;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, expected none actual %h", $time,
                 {result_ch.frame_found, result_ch.xor_key, result_ch.card_number});
        mismatches++;
      end else begin
        next_decode = expected_results.pop_front();
        check_field("frame_found", 16'(next_decode.frame_found),
                    16'(result_ch.frame_found));
        check_field("xor_key", 16'(next_decode.xor_key), 16'(result_ch.xor_key));
        check_field("card_length", 16'(next_decode.card_length),
                    16'(result_ch.card_length));
        check_field("crc_bits", 16'(next_decode.crc_bits), 16'(result_ch.crc_bits));
        check_field("profile_code", next_decode.profile_code, result_ch.profile_code);
        check_field("facility_number", 16'(next_decode.facility_number),
                    16'(result_ch.facility_number));
        check_field("card_number", next_decode.card_number, result_ch.card_number);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (pulse_ch.valid && pulse_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("biphase_rfid_frame_decoder: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = REG_SHORT_NOM;
    cfg_data                = '0;
    pulse_ch.valid          = 1'b0;
    pulse_ch.pulse_duration = '0;
    gaps_on                 = 1'b1;
    hold_req                = 0;
    pulses_sent             = 0;
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_window_edges();
    test_overlap_priority();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();
    test_final_frame();

    // drain, then a settling wait for anything stray
    pulse_ch.valid = 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (2 * PIPE_SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("biphase_rfid_frame_decoder: match");
    else
      $display("biphase_rfid_frame_decoder: mismatch");
    $finish;
  end

endmodule

// File: biphase_rfid_frame_decoder.f
rtl/core/bprf_pkg.sv
rtl/core/bprf_pulse_if.sv
rtl/core/bprf_result_if.sv
rtl/core/bprf_cfg_regs.sv
rtl/core/bprf_bit_decoder.sv
rtl/core/bprf_frame_check.sv
rtl/core/biphase_rfid_frame_decoder.sv
sim/biphase_rfid_frame_decoder_tb.sv
